@@ hw/rtl/pvd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvd_pkg
// shared types and constants of the polygon vertex decimation block
// ----------------------------------------------------------------------------
package pvd_pkg;

    localparam int MAX_POLY_VERTICES = 32;
    localparam int COORD_BITS        = 12;
    localparam int CFG_BITS          = 6;
    localparam logic [CFG_BITS-1:0] MAX_VERTICES_RESET = 6'd4;

    // register byte addresses
    localparam logic [1:0] ADDR_MAX_VERTICES = 2'd0;

    typedef struct packed {
        logic [COORD_BITS-1:0] vert_x;
        logic [COORD_BITS-1:0] vert_y;
        logic                  vert_last;
    } vert_in_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] out_x;
        logic [COORD_BITS-1:0] out_y;
        logic                  out_last;
        logic                  overflow;
    } vert_out_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CHECK,
        ST_SCAN,
        ST_REMOVE,
        ST_EMIT
    } pvd_state_t;

    // control from sequencer to the cell row
    typedef struct packed {
        logic load;      // write incoming vertex at the next free slot
        logic remove;    // close gap at the selected vertex
    } cell_ctrl_t;

endpackage

@@ hw/rtl/polygon_vertex_decimation_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_vertex_decimation_core
// reduces a closed polygon to at most max_vertices (zero acts as one) by
// removing the vertex nearest its neighbors' chord, then streams survivors out
// ----------------------------------------------------------------------------
// usage:
//   input channel carries one vertex word per accept; vert_last closes the
//   polygon. up to MAX_POLY_VERTICES words are stored, more are dropped and
//   reported through the overflow bit of every result word.
//   while loading the input never stalls. after the last word, each removal
//   pass measures the candidates one at a time through a pipelined measure
//   and compare unit, taking the next only once the last compare resolves;
//   a pass also holds the check and the gap close in the cell row.
//   when nothing is removed the first survivor is offered once the sequencer
//   has gone from load through the check state to emit; survivors then leave
//   one word per cycle while the receiver does not stall.
//   while reducing or emitting the input stall is high.
//   a stalled output word holds; emission waits on the receiver.
//   reset clears the vertex count, the overflow flag and sets max_vertices
//   to 4; stored coordinates are undefined until written.
//   max_vertices sits at byte address 0 of the apb port.
// ----------------------------------------------------------------------------
module polygon_vertex_decimation_core #(
    parameter int MAX_POLY_VERTICES = pvd_pkg::MAX_POLY_VERTICES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pvd_pkg::vert_in_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output pvd_pkg::vert_out_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import pvd_pkg::*;

    localparam int N   = MAX_POLY_VERTICES;
    localparam int IW  = $clog2(N);
    localparam int CW  = $clog2(N + 1);
    localparam int PW  = 2*COORD_BITS + 2;
    localparam int LAT = 4;   // measure 2 stages + compare 2 stages

    pvd_state_t state_reg, state_next;
    logic [CFG_BITS-1:0] maxv_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [CW-1:0]       scan_reg, scan_next;   // vertices issued
    logic [CW-1:0]       done_reg, done_next;   // vertices compared
    logic [IW-1:0]       best_reg, best_next;
    logic [PW-1:0]       cmin_reg, lmin_reg;
    logic [PW-1:0]       cdl_reg [LAT-2];
    logic [PW-1:0]       ldl_reg [LAT-2];
    logic [CW-1:0]       limit;
    logic [COORD_BITS-1:0] cx [N];
    logic [COORD_BITS-1:0] cy [N];
    logic [N-1:0]        load_en, take_next;
    cell_ctrl_t          ctrl;
    logic [IW-1:0]       head_reg, head_next;   // rotation of the row
    logic [PW-1:0]       c_now, l_now;
    logic                closer;
    logic [IW-1:0]       pi, ni;
    logic                in_acc, out_acc;
    logic                first_cmp;

    // ---------------- config port
    assign pready = 1'b1;
    assign prdata = {{(32-CFG_BITS){1'b0}}, maxv_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            maxv_reg <= MAX_VERTICES_RESET;
        else if (psel && penable && pwrite && paddr == ADDR_MAX_VERTICES)
            maxv_reg <= pwdata[CFG_BITS-1:0];
    end

    // limits above the capacity keep everything
    assign limit = (maxv_reg == '0) ? CW'(1) :
                   (int'(maxv_reg) >= N) ? CW'(N) : CW'(maxv_reg);

    // ---------------- cell row: vertex k lives at cell (head + k) mod N
    function automatic logic [IW-1:0] wrap(input logic [IW:0] v);
        logic [IW:0] r;
        r = (v >= (IW+1)'(N)) ? v - (IW+1)'(N) : v;
        return r[IW-1:0];
    endfunction

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            logic [IW-1:0] rel;
            assign rel = wrap((IW+1)'(g) + (IW+1)'(N) - (IW+1)'(head_reg));
            assign load_en[g]   = ctrl.load && (rel == count_reg[IW-1:0]);
            assign take_next[g] = ctrl.remove && (rel >= best_reg)
                                  && (CW'(rel) + CW'(1) < count_reg);
            pvd_cell #(.COORD_W(COORD_BITS)) u_cell (
                .clk      (clk),
                .load_en  (load_en[g]),
                .take_next(take_next[g]),
                .load_x   (in_data.vert_x[COORD_BITS-1:0]),
                .load_y   (in_data.vert_y[COORD_BITS-1:0]),
                .next_x   (cx[(g + 1) % N]),
                .next_y   (cy[(g + 1) % N]),
                .x        (cx[g]),
                .y        (cy[g])
            );
        end
    endgenerate

    // vertex scan_reg is measured with neighbors from the live row
    logic [IW-1:0] ci;
    always_comb
    begin
        logic [IW:0] i_rel, p_rel, n_rel;
        i_rel = (IW+1)'(scan_reg[IW-1:0]);
        p_rel = (scan_reg == '0) ? (IW+1)'(count_reg - CW'(1)) : i_rel - (IW+1)'(1);
        n_rel = (CW'(scan_reg) + CW'(1) == count_reg) ? '0 : i_rel + (IW+1)'(1);
        ci = wrap(i_rel + (IW+1)'(head_reg));
        pi = wrap(p_rel + (IW+1)'(head_reg));
        ni = wrap(n_rel + (IW+1)'(head_reg));
    end

    pvd_measure #(.COORD_W(COORD_BITS)) u_meas (
        .clk      (clk),
        .ax       (cx[pi]), .ay(cy[pi]),
        .px       (cx[ci]), .py(cy[ci]),
        .bx       (cx[ni]), .by(cy[ni]),
        .cross_abs(c_now),
        .len2     (l_now)
    );

    // hold measures until the compare resolves
    always_ff @(posedge clk)
    begin
        cdl_reg[0] <= c_now;
        ldl_reg[0] <= l_now;
        cdl_reg[1] <= cdl_reg[0];
        ldl_reg[1] <= ldl_reg[0];
    end

    pvd_compare #(.COORD_W(COORD_BITS)) u_cmp (
        .clk   (clk),
        .c_cand(c_now),
        .l_cand(l_now),
        .c_min (cmin_reg),
        .l_min (lmin_reg),
        .closer(closer)
    );

    // ---------------- sequencer
    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;
    assign in_stall  = (state_reg != ST_LOAD);
    assign out_valid = (state_reg == ST_EMIT);
    assign first_cmp = (done_reg == '0);

    always_comb
    begin
        logic [IW:0] e_rel;
        e_rel = (IW+1)'(scan_reg[IW-1:0]) + (IW+1)'(head_reg);
        out_data.out_x    = cx[wrap(e_rel)];
        out_data.out_y    = cy[wrap(e_rel)];
        out_data.out_last = (scan_reg + CW'(1) == count_reg);
        out_data.overflow = ovf_reg;
    end

    // the compare sees one candidate per cycle against a minimum that is only
    // final once the last candidate is through, so candidates go one at a time
    logic [2:0] wait_reg, wait_next;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        scan_next  = scan_reg;
        done_next  = done_reg;
        best_next  = best_reg;
        head_next  = head_reg;
        wait_next  = wait_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (count_reg < CW'(N))
                    begin
                        ctrl.load  = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                        ovf_next = 1'b1;
                    if (in_data.vert_last)
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                scan_next = '0;
                done_next = '0;
                best_next = '0;
                wait_next = '0;
                if (count_reg > limit)
                    state_next = ST_SCAN;
                else
                    state_next = ST_EMIT;
            end
            ST_SCAN:
            begin
                wait_next = wait_reg + 3'd1;
                if (wait_reg == 3'(LAT))
                begin
                    wait_next = '0;
                    if (first_cmp || closer)
                        best_next = scan_reg[IW-1:0];
                    done_next = done_reg + CW'(1);
                    if (scan_reg + CW'(1) == count_reg)
                        state_next = ST_REMOVE;
                    else
                        scan_next = scan_reg + CW'(1);
                end
            end
            ST_REMOVE:
            begin
                ctrl.remove = 1'b1;
                count_next  = count_reg - CW'(1);
                state_next  = ST_CHECK;
            end
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    if (scan_reg + CW'(1) >= count_reg)
                    begin
                        state_next = ST_LOAD;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        scan_next  = '0;
                        head_next  = '0;
                    end
                    else
                        scan_next = scan_reg + CW'(1);
                end
                else if (count_reg == '0)
                begin
                    state_next = ST_LOAD;
                    ovf_next   = 1'b0;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // running minimum: latch the candidate measure when it wins
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN && wait_reg == 3'(LAT) && (first_cmp || closer))
        begin
            cmin_reg <= cdl_reg[1];
            lmin_reg <= ldl_reg[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            scan_reg  <= '0;
            done_reg  <= '0;
            best_reg  <= '0;
            head_reg  <= '0;
            wait_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            scan_reg  <= scan_next;
            done_reg  <= done_next;
            best_reg  <= best_next;
            head_reg  <= head_next;
            wait_reg  <= wait_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(N)) else $error("vertex count beyond capacity");
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |-> state_reg == ST_LOAD) else $error("load outside load phase");
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(scan_reg))
        else $error("stalled word moved");
    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.remove |=> count_reg == $past(count_reg) - CW'(1))
        else $error("remove did not shrink count");
`endif

endmodule

@@ hw/rtl/pvd_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvd_cell
// one vertex slot of the storage row; loads and closes gaps
// ----------------------------------------------------------------------------
module pvd_cell #(
    parameter int COORD_W = pvd_pkg::COORD_BITS
) (
    input  logic               clk,
    input  logic               load_en,
    input  logic               take_next,
    input  logic [COORD_W-1:0] load_x,
    input  logic [COORD_W-1:0] load_y,
    input  logic [COORD_W-1:0] next_x,
    input  logic [COORD_W-1:0] next_y,
    output logic [COORD_W-1:0] x,
    output logic [COORD_W-1:0] y
);
    import pvd_pkg::*;

    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            x_reg <= load_x;
            y_reg <= load_y;
        end
        else if (take_next)
        begin
            x_reg <= next_x;
            y_reg <= next_y;
        end
    end

    assign x = x_reg;
    assign y = y_reg;

endmodule

@@ hw/rtl/pvd_measure.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvd_measure
// pipelined distance measure: cross magnitude and squared chord length
// ----------------------------------------------------------------------------
module pvd_measure #(
    parameter int COORD_W = pvd_pkg::COORD_BITS
) (
    input  logic               clk,
    input  logic [COORD_W-1:0] ax,
    input  logic [COORD_W-1:0] ay,
    input  logic [COORD_W-1:0] px,
    input  logic [COORD_W-1:0] py,
    input  logic [COORD_W-1:0] bx,
    input  logic [COORD_W-1:0] by,
    output logic [2*COORD_W+1:0] cross_abs,
    output logic [2*COORD_W+1:0] len2
);
    import pvd_pkg::*;

    localparam int DW = COORD_W + 1;
    localparam int PW = 2*COORD_W + 2;

    logic signed [DW-1:0] dx, dy, ex, ey;
    logic signed [DW-1:0] dx_reg, dy_reg, ex_reg, ey_reg;
    logic signed [PW:0]   c1_reg, c2_reg;
    logic [PW-1:0]        l1_reg, l2_reg;
    logic signed [PW:0]   c;

    assign dx = $signed({1'b0, bx}) - $signed({1'b0, ax});
    assign dy = $signed({1'b0, by}) - $signed({1'b0, ay});
    assign ex = $signed({1'b0, ay}) - $signed({1'b0, py});
    assign ey = $signed({1'b0, ax}) - $signed({1'b0, px});

    always_ff @(posedge clk)
    begin
        dx_reg <= dx;
        dy_reg <= dy;
        ex_reg <= ex;
        ey_reg <= ey;
        c1_reg <= (PW+1)'(dx_reg) * (PW+1)'(ex_reg);
        c2_reg <= (PW+1)'(dy_reg) * (PW+1)'(ey_reg);
        l1_reg <= PW'((PW+1)'(dx_reg) * (PW+1)'(dx_reg));
        l2_reg <= PW'((PW+1)'(dy_reg) * (PW+1)'(dy_reg));
    end

    assign c         = c1_reg - c2_reg;
    assign cross_abs = c[PW] ? PW'(-c) : PW'(c);
    assign len2      = l1_reg + l2_reg;

endmodule

@@ hw/rtl/pvd_compare.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvd_compare
// exact c*c*l ordering; squares and products registered per stage
// ----------------------------------------------------------------------------
module pvd_compare #(
    parameter int COORD_W = pvd_pkg::COORD_BITS
) (
    input  logic                   clk,
    input  logic [2*COORD_W+1:0]   c_cand,
    input  logic [2*COORD_W+1:0]   l_cand,
    input  logic [2*COORD_W+1:0]   c_min,
    input  logic [2*COORD_W+1:0]   l_min,
    output logic                   closer
);
    import pvd_pkg::*;

    localparam int PW = 2*COORD_W + 2;

    logic [2*PW-1:0] sq_a_reg, sq_b_reg;
    logic [PW-1:0]   la_reg, lb_reg;
    logic            zc_reg, zm_reg, zc2_reg, zm2_reg;
    logic [2*PW-1:0] ha_reg, lo_a_reg, hb_reg, lo_b_reg;
    logic [3*PW-1:0] t_a, t_b;

    // stage 1: squares of cross magnitudes
    always_ff @(posedge clk)
    begin
        sq_a_reg <= c_cand * c_cand;
        sq_b_reg <= c_min * c_min;
        la_reg   <= l_min;
        lb_reg   <= l_cand;
        zc_reg   <= (l_cand == '0);
        zm_reg   <= (l_min == '0);
    end

    // stage 2: cross by chord length (split across the wide product)
    always_ff @(posedge clk)
    begin
        ha_reg   <= sq_a_reg[2*PW-1:PW] * la_reg;
        lo_a_reg <= sq_a_reg[PW-1:0] * la_reg;
        hb_reg   <= sq_b_reg[2*PW-1:PW] * lb_reg;
        lo_b_reg <= sq_b_reg[PW-1:0] * lb_reg;
        zc2_reg  <= zc_reg;
        zm2_reg  <= zm_reg;
    end

    assign t_a = {ha_reg, {PW{1'b0}}} + {{PW{1'b0}}, lo_a_reg};
    assign t_b = {hb_reg, {PW{1'b0}}} + {{PW{1'b0}}, lo_b_reg};

    always_comb
    begin
        priority if (zc2_reg)
            closer = 1'b0;
        else if (zm2_reg)
            closer = 1'b1;
        else
            closer = (t_a < t_b);
    end

endmodule

@@ bench/pvd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvd_checker
// watches the vertex and result channels and the apb writes, models the
// decimation of every closed polygon and compares each result word in order
// ----------------------------------------------------------------------------
module pvd_checker
    import pvd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  vert_in_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  vert_out_t out_data,
    input  logic      psel,
    input  logic      penable,
    input  logic      pwrite,
    input  logic [1:0] paddr,
    input  logic [31:0] pwdata,
    input  logic      pready,
    output int        fail_count,
    output int        pending
);

    logic [11:0] poly_x [MAX_POLY_VERTICES];
    logic [11:0] poly_y [MAX_POLY_VERTICES];
    int          poly_len;
    bit          poly_dropped;
    logic [5:0]  keep_limit;
    vert_out_t   survivors_q[$];

    assign pending = survivors_q.size();

    // cross product magnitude and squared chord length around vertex i
    function automatic void chord_metric(input int n, input int i,
                                         output longint unsigned cr,
                                         output longint unsigned ln);
        longint ax, ay, bx, by, px, py, dx, dy, c;
        ax = poly_x[(i + n - 1) % n]; ay = poly_y[(i + n - 1) % n];
        bx = poly_x[(i + 1) % n];     by = poly_y[(i + 1) % n];
        px = poly_x[i];               py = poly_y[i];
        dx = bx - ax; dy = by - ay;
        c  = dx * (ay - py) - dy * (ax - px);
        cr = (c < 0) ? -c : c;
        ln = dx * dx + dy * dy;
    endfunction

    function automatic bit nearer(longint unsigned cc, longint unsigned lc,
                                  longint unsigned cm, longint unsigned lm);
        logic [191:0] a, b;
        if (lc == 0) return 0;
        if (lm == 0) return 1;
        a = 192'(cc) * 192'(cc) * 192'(lm);
        b = 192'(cm) * 192'(cm) * 192'(lc);
        return a < b;
    endfunction

    task automatic decimate_and_queue();
        int lim, n, best;
        longint unsigned cm, lm, c, l;
        vert_out_t w;
        lim = (keep_limit == 0) ? 1 : keep_limit;
        while (poly_len > lim) begin
            n = poly_len;
            best = 0;
            chord_metric(n, 0, cm, lm);
            for (int i = 1; i < n; i++) begin
                chord_metric(n, i, c, l);
                if (nearer(c, l, cm, lm)) begin
                    cm = c; lm = l; best = i;
                end
            end
            for (int i = best; i + 1 < n; i++) begin
                poly_x[i] = poly_x[i+1];
                poly_y[i] = poly_y[i+1];
            end
            poly_len--;
        end
        for (int i = 0; i < poly_len; i++) begin
            w.out_x = poly_x[i];
            w.out_y = poly_y[i];
            w.out_last = (i + 1 == poly_len);
            w.overflow = poly_dropped;
            survivors_q = {survivors_q, w};
        end
        poly_len = 0;
        poly_dropped = 0;
    endtask

    always @(posedge clk or negedge rst_n) begin
        vert_out_t exp_w;
        if (!rst_n) begin
            poly_len = 0;
            poly_dropped = 0;
            keep_limit = MAX_VERTICES_RESET;
            survivors_q.delete();
            fail_count = 0;
        end
        else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_MAX_VERTICES)
                keep_limit = pwdata[5:0];
            if (out_valid && !out_stall) begin
                if (survivors_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word %h", out_data);
                end
                else begin
                    exp_w = survivors_q.pop_front();
                    if (exp_w !== out_data) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("word wrong: exp x=%0d y=%0d last=%0b ovf=%0b, got x=%0d y=%0d last=%0b ovf=%0b",
                                     exp_w.out_x, exp_w.out_y, exp_w.out_last, exp_w.overflow,
                                     out_data.out_x, out_data.out_y, out_data.out_last,
                                     out_data.overflow);
                    end
                end
            end
            if (in_valid && !in_stall) begin
                if (poly_len < MAX_POLY_VERTICES) begin
                    poly_x[poly_len] = in_data.vert_x;
                    poly_y[poly_len] = in_data.vert_y;
                    poly_len++;
                end
                else
                    poly_dropped = 1;
                if (in_data.vert_last)
                    decimate_and_queue();
            end
        end
    end

endmodule

@@ bench/tb_polygon_vertex_decimation_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polygon_vertex_decimation_core
// drives random and corner-case polygons through the decimation core under
// random idling and stalls, over several max_vertices settings
// ----------------------------------------------------------------------------
module tb_polygon_vertex_decimation_core;
    import pvd_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    vert_in_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 0;
    vert_out_t   out_data;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending;
    int          quiet_cycles = 0;
    bit          idle_enable = 1;
    int          sent = 0;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    polygon_vertex_decimation_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    pvd_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending(pending)
    );

    // receiver stalls in bursts
    always @(posedge clk)
    begin
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1;
            repeat ($urandom_range(1, 19)) @(posedge clk);
            out_stall <= 0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("polygon_vertex_decimation_core: mismatch");
            $finish;
        end
    end

    // valid stays high between back to back words and drops only for idling or a drain
    task automatic send_vertex(input logic [11:0] x, input logic [11:0] y,
                               input logic last);
        if (idle_enable && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1;
        in_data  <= '{vert_x: x, vert_y: y, vert_last: last};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_limit(input logic [5:0] v);
        psel <= 1; pwrite <= 1; paddr <= ADDR_MAX_VERTICES; pwdata <= 32'(v);
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge clk);
    endtask

    task automatic random_polygon(input int n);
        for (int i = 0; i < n; i++)
            send_vertex($urandom_range(0, 4095), $urandom_range(0, 4095), i == n - 1);
    endtask

    initial
    begin
        int n;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: single vertex, two vertices, collinear, extremes, ties
        send_vertex(12'd0, 12'd0, 1);
        send_vertex(12'hfff, 12'hfff, 0);
        send_vertex(12'hfff, 12'hfff, 1);
        send_vertex(12'd0, 12'd0, 0);
        send_vertex(12'd100, 12'd100, 0);
        send_vertex(12'd200, 12'd200, 0);
        send_vertex(12'hfff, 12'd0, 0);
        send_vertex(12'd0, 12'hfff, 0);
        send_vertex(12'd5, 12'd5, 1);
        send_vertex(12'd0, 12'd0, 0);
        send_vertex(12'd10, 12'd0, 0);
        send_vertex(12'd10, 12'd10, 0);
        send_vertex(12'd0, 12'd10, 0);
        send_vertex(12'd0, 12'd0, 0);
        send_vertex(12'haaa, 12'h555, 0);
        send_vertex(12'h555, 12'haaa, 1);
        drain();

        // limit zero acts as one
        write_limit(6'd0);
        random_polygon(3);
        drain();

        // overflow: past capacity, final one dropped too
        write_limit(6'd63);
        random_polygon(35);
        drain();

        write_limit(6'd32);
        random_polygon(32);
        drain();

        write_limit(6'd1);
        random_polygon(6);
        drain();

        // random phase over several limits
        for (int phase = 0; phase < 6; phase++)
        begin
            write_limit(phase == 5 ? 6'd4 : 6'($urandom_range(0, 40)));
            for (int p = 0; p < 3; p++)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36)
                                                : $urandom_range(1, 8);
                if (phase == 5 && p >= 1)
                    idle_enable = 0;
                random_polygon(n);
            end
            drain();
        end

        while (sent < 220)
            random_polygon($urandom_range(1, 6));
        drain();

        if (fail_count == 0)
            $display("polygon_vertex_decimation_core: match");
        else
            $display("polygon_vertex_decimation_core: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/pvd_pkg.sv
hw/rtl/pvd_cell.sv
hw/rtl/pvd_measure.sv
hw/rtl/pvd_compare.sv
hw/rtl/polygon_vertex_decimation_core.sv
bench/pvd_checker.sv
bench/tb_polygon_vertex_decimation_core.sv
